// File: rtl/assert_macros.svh
// Assertion helpers shared by the hasher modules.
// With SYNTHESIS defined the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

// File: rtl/md5sh_pkg.sv
package md5sh_pkg;

   // Widths of the message state.
   localparam int COUNT_W   = 61;
   localparam int ROUNDS    = 64;
   localparam int WORDS     = 16;
   localparam int ROUND_W   = $clog2(ROUNDS);
   localparam int WORD_IX_W = $clog2(WORDS);
   localparam int BYTE_IX_W = ROUND_W;

   // Padding layout: the length occupies the last two words of a block.
   localparam logic [BYTE_IX_W-1:0] PAD_LIMIT   = 6'd56;
   localparam logic [WORD_IX_W-1:0] LEN_WORD_LO = 4'd14;
   localparam logic [WORD_IX_W-1:0] LEN_WORD_HI = 4'd15;
   localparam logic [7:0]           PAD_BYTE    = 8'h80;
   localparam logic [BYTE_IX_W-1:0] LAST_BYTE   = 6'd63;

   // Initial chaining words A, B, C, D.
   localparam logic [31:0] CHAIN_INIT [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   // Additive constants, one per round.
   localparam logic [31:0] ROUND_CONST [ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Left rotate amounts, four per quarter of the rounds.
   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT0,
      ST_OUT1
   } ctrl_state_type;

   // Kind of block being compressed.
   typedef enum logic [1:0] {
      MODE_DATA,
      MODE_PAD_FIRST,
      MODE_PAD_LAST
   } block_mode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic pad_write;
      logic start;
      logic round;
      logic finish;
      logic set_tail;
      logic reinit;
      logic out_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [BYTE_IX_W-1:0] used;
      logic                 pad_fits;
      logic                 last_round;
   } status_type;

   // Message word used by a given round.
   function automatic logic [WORD_IX_W-1:0] word_index(input logic [ROUND_W-1:0] rnd);
      logic [WORD_IX_W-1:0] x;
      logic [WORD_IX_W-1:0] g;
      x = rnd[WORD_IX_W-1:0];
      case (rnd[ROUND_W-1:ROUND_W-2])
         2'd0:    g = x;
         2'd1:    g = (x << 2) + x + 4'd1;
         2'd2:    g = (x << 1) + x + 4'd5;
         default: g = (x << 3) - x;
      endcase
      return g;
   endfunction

endpackage

// File: rtl/md5sh_ctrl.sv
`include "assert_macros.svh"

module md5sh_ctrl import md5sh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_has_byte,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_part_index,
   output logic       rsp_last_part,
   output cmd_type    cmd,
   input  status_type status
);

   ctrl_state_type state_ff, state_in;
   block_mode_type mode_ff, mode_in;
   logic           eom_pend_ff, eom_pend_in;

   // State and block bookkeeping registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         mode_ff     <= MODE_DATA;
         eom_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         eom_pend_ff <= eom_pend_in;
      end
   end

   // Next state.
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      eom_pend_in = eom_pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_has_byte && status.used == LAST_BYTE) begin
                  state_in    = ST_LOAD;
                  mode_in     = MODE_DATA;
                  eom_pend_in = req_end_of_message;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            state_in    = ST_LOAD;
            eom_pend_in = 1'b0;
            mode_in     = status.pad_fits ? MODE_PAD_LAST : MODE_PAD_FIRST;
         end
         ST_LOAD: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (status.last_round) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            case (mode_ff)
               MODE_DATA: begin
                  state_in = eom_pend_ff ? ST_PAD : ST_IDLE;
               end
               MODE_PAD_FIRST: begin
                  state_in = ST_LOAD;
                  mode_in  = MODE_PAD_LAST;
               end
               default: begin
                  state_in = ST_OUT0;
               end
            endcase
         end
         ST_OUT0: begin
            if (!rsp_stall) begin
               state_in = ST_OUT1;
            end
         end
         ST_OUT1: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      cmd            = '0;
      req_stall      = 1'b1;
      rsp_valid      = 1'b0;
      rsp_part_index = 1'b0;
      rsp_last_part  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_PAD: begin
            cmd.pad_write = 1'b1;
         end
         ST_LOAD: begin
            cmd.start = 1'b1;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
         end
         ST_ADD: begin
            cmd.finish   = 1'b1;
            cmd.set_tail = (mode_ff == MODE_PAD_FIRST);
         end
         ST_OUT0: begin
            rsp_valid = 1'b1;
         end
         ST_OUT1: begin
            rsp_valid      = 1'b1;
            rsp_part_index = 1'b1;
            rsp_last_part  = 1'b1;
            cmd.out_sel    = 1'b1;
            cmd.reinit     = !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // The 64th round always hands over to the chaining update.
   `ASSERT_ALWAYS(a_round_to_add, clock, reset, (state_ff == ST_ROUND && status.last_round) |=> (state_ff == ST_ADD), "compression did not end after the last round")
   // Datapath operations never overlap.
   `ASSERT_ALWAYS(a_cmd_onehot, clock, reset, $onehot0({cmd.accept, cmd.pad_write, cmd.start, cmd.round, cmd.finish, cmd.reinit}), "conflicting datapath commands")
   // A pad block that leaves no room for the length is followed by a tail block.
   `ASSERT_ALWAYS(a_tail_block, clock, reset, (state_ff == ST_ADD && mode_ff == MODE_PAD_FIRST) |=> (state_ff == ST_LOAD && mode_ff == MODE_PAD_LAST), "missing length block")

endmodule

// File: rtl/md5sh_datapath.sv
`include "assert_macros.svh"

module md5sh_datapath import md5sh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [63:0] rsp_digest_part
);

   logic [31:0]          buf_mem [WORDS];
   logic [31:0]          rd_data_ff;
   logic [WORD_IX_W-1:0] rd_word_ff;
   logic [WORD_IX_W-1:0] rd_addr;
   logic                 wr_en;
   logic [7:0]           wr_byte;

   logic [31:0]          chain_ff [4];
   logic [COUNT_W-1:0]   count_ff;
   logic [31:0]          wa_ff, wb_ff, wc_ff, wd_ff;
   logic [ROUND_W-1:0]   round_ff;
   logic [6:0]           limit_ff;
   logic                 len_en_ff;

   logic [BYTE_IX_W-1:0] used;
   logic [63:0]          bit_len;
   logic [31:0]          msg_word;
   logic [6:0]           byte_pos;
   logic [31:0]          func_f;
   logic [31:0]          sum;
   logic [63:0]          rot_wide;
   logic [31:0]          new_b;

   function automatic logic [31:0] bswap(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   assign used    = count_ff[BYTE_IX_W-1:0];
   assign bit_len = {count_ff, 3'b000};

   // Block buffer: byte writes into words, registered word reads.
   assign wr_en   = (cmd.accept && req_has_byte) || cmd.pad_write;
   assign wr_byte = cmd.pad_write ? PAD_BYTE : req_data_byte;
   assign rd_addr = cmd.start ? word_index('0) : word_index(round_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[used[BYTE_IX_W-1:2]][8*used[1:0] +: 8] <= wr_byte;
      end
      rd_data_ff <= buf_mem[rd_addr];
      rd_word_ff <= rd_addr;
   end

   // Message word seen by the round: bytes past the limit read as zero,
   // and the bit length replaces the last two words of the final block.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         byte_pos = {1'b0, rd_word_ff, 2'(j)};
         msg_word[8*j +: 8] = (byte_pos < limit_ff) ? rd_data_ff[8*j +: 8] : 8'h00;
      end
      if (len_en_ff && rd_word_ff == LEN_WORD_LO) begin
         msg_word = bit_len[31:0];
      end else if (len_en_ff && rd_word_ff == LEN_WORD_HI) begin
         msg_word = bit_len[63:32];
      end
   end

   // One compression round.
   always_comb begin
      case (round_ff[ROUND_W-1:ROUND_W-2])
         2'd0:    func_f = wd_ff ^ (wb_ff & (wc_ff ^ wd_ff));
         2'd1:    func_f = wc_ff ^ (wd_ff & (wb_ff ^ wc_ff));
         2'd2:    func_f = wb_ff ^ wc_ff ^ wd_ff;
         default: func_f = wc_ff ^ (wb_ff | ~wd_ff);
      endcase
      sum      = wa_ff + func_f + ROUND_CONST[round_ff] + msg_word;
      rot_wide = {sum, sum} << ROT_AMOUNT[{round_ff[ROUND_W-1:ROUND_W-2], round_ff[1:0]}];
      new_b    = wb_ff + rot_wide[63:32];
   end

   // Working variables and round counter.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         wa_ff    <= chain_ff[0];
         wb_ff    <= chain_ff[1];
         wc_ff    <= chain_ff[2];
         wd_ff    <= chain_ff[3];
         round_ff <= '0;
      end else if (cmd.round) begin
         wa_ff    <= wd_ff;
         wb_ff    <= new_b;
         wc_ff    <= wb_ff;
         wd_ff    <= wc_ff;
         round_ff <= round_ff + 1'b1;
      end
   end

   // Block limit and length insertion for the block about to be compressed.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         limit_ff  <= 7'(ROUNDS);
         len_en_ff <= 1'b0;
      end else if (cmd.pad_write) begin
         limit_ff  <= {1'b0, used} + 7'd1;
         len_en_ff <= (used < PAD_LIMIT);
      end else if (cmd.set_tail) begin
         limit_ff  <= '0;
         len_en_ff <= 1'b1;
      end
   end

   // Chaining words and byte count.
   always_ff @(posedge clock) begin
      if (reset || cmd.reinit) begin
         for (int k = 0; k < 4; k++) begin
            chain_ff[k] <= CHAIN_INIT[k];
         end
         count_ff <= '0;
      end else begin
         if (cmd.finish) begin
            chain_ff[0] <= chain_ff[0] + wa_ff;
            chain_ff[1] <= chain_ff[1] + wb_ff;
            chain_ff[2] <= chain_ff[2] + wc_ff;
            chain_ff[3] <= chain_ff[3] + wd_ff;
         end
         if (cmd.accept && req_has_byte) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // Digest bytes in standard order, each word little-endian.
   assign rsp_digest_part = cmd.out_sel ? {bswap(chain_ff[2]), bswap(chain_ff[3])}
                                        : {bswap(chain_ff[0]), bswap(chain_ff[1])};

   assign status.used       = used;
   assign status.pad_fits   = (used < PAD_LIMIT);
   assign status.last_round = &round_ff;

   // A new message always starts at the beginning of a block.
   `ASSERT_ALWAYS(a_reinit_clears, clock, reset, cmd.reinit |=> (status.used == '0 && chain_ff[0] == CHAIN_INIT[0]), "hasher not reinitialized")

endmodule

// File: rtl/md5_stream_hasher.sv
// MD5 stream hasher. Takes one message byte per word on the req_ channel
// (req_has_byte marks a byte, req_end_of_message closes the message after
// any byte of the same word) and returns the 128-bit digest as two 64-bit
// words on the rsp_ channel, first digest byte in bits 63 to 56 of part 0.
// A byte that does not complete a 64-byte block leaves the hasher idle. The
// byte that completes a block starts a compression: one buffer read, then
// 64 rounds through a single round unit, then one chaining update. End of
// message writes the pad byte and then runs one compression, or two when
// 56 or more bytes of the last block are used, before the two digest words
// are offered. The hasher starts over with a fresh state after the second
// digest word is taken. req_stall is high whenever the block is not idle.
module md5_stream_hasher import md5sh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_part,
   output logic        rsp_part_index,
   output logic        rsp_last_part
);

   cmd_type    cmd;
   status_type status;

   // Sequencer for byte intake, padding, compression and digest output.
   md5sh_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_part_index     (rsp_part_index),
      .rsp_last_part      (rsp_last_part),
      .cmd                (cmd),
      .status             (status)
   );

   // Block buffer, round unit, chaining words and byte count.
   md5sh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .req_has_byte    (req_has_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_digest_part (rsp_digest_part)
   );

endmodule
